// ===== hdl/sqc_pkg.sv =====
// Shared types, character codes and acceptor table for the sequential calculator.
package sqc_pkg;

  typedef enum logic [1:0] {
    OP_PLUS,
    OP_MINUS,
    OP_TIMES,
    OP_DIVIDE
  } op_t;

  typedef enum logic [1:0] {
    CLS_DIGIT,
    CLS_OPER,
    CLS_OTHER
  } cls_t;

  typedef enum logic [1:0] {
    AS_ACCEPT,
    AS_AFTER_OP,
    AS_DEAD
  } acc_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_START_A,
    CS_WAIT_A,
    CS_START_B,
    CS_WAIT_B,
    CS_EMIT
  } ctl_state_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_ADD,
    FS_MUL,
    FS_NEG_A,
    FS_NEG_B,
    FS_DIV,
    FS_NEG_Q,
    FS_DONE
  } fold_state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } fold_req_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic div_zero;
  } fold_rsp_t;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_TIMES  = 8'h2A;
  localparam logic [7:0] CH_DIVIDE = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [1:0] STATUS_IGNORED = 2'd3;

  function automatic cls_t classify(input logic [7:0] ch);
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      return CLS_DIGIT;
    end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_TIMES || ch == CH_DIVIDE) begin
      return CLS_OPER;
    end else begin
      return CLS_OTHER;
    end
  endfunction

  function automatic op_t op_of(input logic [7:0] ch);
    case (ch)
      CH_PLUS:  return OP_PLUS;
      CH_MINUS: return OP_MINUS;
      CH_TIMES: return OP_TIMES;
      default:  return OP_DIVIDE;
    endcase
  endfunction

  // acceptor transitions: rows by state, columns by character class
  function automatic acc_state_t next_accept(input acc_state_t s, input cls_t c);
    case (s)
      AS_ACCEPT: begin
        case (c)
          CLS_DIGIT: return AS_ACCEPT;
          CLS_OPER:  return AS_AFTER_OP;
          default:   return AS_DEAD;
        endcase
      end
      AS_AFTER_OP: begin
        case (c)
          CLS_DIGIT: return AS_ACCEPT;
          default:   return AS_DEAD;
        endcase
      end
      default: return AS_DEAD;
    endcase
  endfunction

endpackage

// ===== hdl/sequential_calculator_dfa_top.sv =====
// Top level: character decode, acceptor, expression state and result register.
//
//  channel | signals                                        | accepted when
//  --------+------------------------------------------------+----------------------
//  in      | in_valid in_ready char_code last_char          | in_valid & in_ready
//  out     | out_valid out_ready status done_res            | out_valid & out_ready
//          | total_value div_zero                           |
//
//  One item at a time; in_ready is high only while the controller is idle.
//  Every fold runs on the one shared adder in sqc_fold. An operator that ends
//  the expression folds twice. A full result register stalls the controller.
//  Synchronous reset returns the expression state to its start values.
module sequential_calculator_dfa_top import sqc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        done_res,
  output logic [31:0] total_value,
  output logic        div_zero
);

  localparam int W = VALUE_WIDTH;

  ctl_state_t   state, state_next;
  acc_state_t   accept_state, accept_nxt;
  cls_t         item_cls;
  logic [7:0]   item_char;
  logic         item_last;
  logic [W-1:0] running_total;
  logic [W-1:0] operand_accum;
  op_t          pending_op;
  logic         skip_rest;
  logic         zero_div_seen;
  logic         res_done;
  logic         res_skip;
  logic         slot_free;

  fold_req_t    fold_req;
  fold_rsp_t    fold_rsp;
  logic [W-1:0] fold_result;

  sqc_fold #(.VALUE_WIDTH(VALUE_WIDTH)) u_fold (
    .clk    (clk),
    .rst    (rst),
    .req    (fold_req),
    .opnd_a (running_total),
    .opnd_b (operand_accum),
    .rsp    (fold_rsp),
    .result (fold_result)
  );

  assign item_cls   = classify(item_char);
  assign accept_nxt = next_accept(accept_state, item_cls);
  assign slot_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE:   if (in_valid) state_next = CS_DECODE;
      CS_DECODE: begin
        if (skip_rest) begin
          state_next = CS_EMIT;
        end else if (item_cls == CLS_OPER) begin
          state_next = CS_START_A;
        end else if (accept_nxt == AS_DEAD || item_last) begin
          state_next = CS_START_B;
        end else begin
          state_next = CS_EMIT;
        end
      end
      CS_START_A: state_next = CS_WAIT_A;
      CS_WAIT_A: begin
        if (fold_rsp.done) begin
          state_next = (accept_nxt == AS_DEAD || item_last) ? CS_START_B : CS_EMIT;
        end
      end
      CS_START_B: state_next = CS_WAIT_B;
      CS_WAIT_B:  if (fold_rsp.done) state_next = CS_EMIT;
      CS_EMIT:    if (slot_free) state_next = CS_IDLE;
      default:    state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == CS_IDLE);
    fold_req.start = (state == CS_START_A) || (state == CS_START_B);
    fold_req.op    = pending_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= CS_IDLE;
      accept_state  <= AS_ACCEPT;
      running_total <= '0;
      operand_accum <= '0;
      pending_op    <= OP_PLUS;
      skip_rest     <= 1'b0;
      zero_div_seen <= 1'b0;
      res_done      <= 1'b0;
      res_skip      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      // the emit state loads a new item into the slot itself
      if (out_valid && out_ready && state != CS_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        CS_IDLE: begin
          if (in_valid) begin
            item_char <= char_code;
            item_last <= last_char;
            res_done  <= 1'b0;
            res_skip  <= 1'b0;
          end
        end
        CS_DECODE: begin
          if (skip_rest) begin
            res_skip <= 1'b1;
          end else if (item_cls != CLS_OPER) begin
            accept_state <= accept_nxt;
            if (item_cls == CLS_DIGIT) begin
              // x*10 + digit as two shifted adds, wrapping at the value width
              operand_accum <= (operand_accum << 3) + (operand_accum << 1)
                             + W'(4'(item_char - CH_ZERO));
            end
          end
        end
        CS_WAIT_A: begin
          if (fold_rsp.done) begin
            running_total <= fold_result;
            zero_div_seen <= zero_div_seen | fold_rsp.div_zero;
            pending_op    <= op_of(item_char);
            operand_accum <= '0;
            accept_state  <= accept_nxt;
          end
        end
        CS_WAIT_B: begin
          if (fold_rsp.done) begin
            running_total <= fold_result;
            zero_div_seen <= zero_div_seen | fold_rsp.div_zero;
            operand_accum <= '0;
            res_done      <= 1'b1;
          end
        end
        CS_EMIT: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            status      <= res_skip ? STATUS_IGNORED : 2'(accept_state);
            done_res    <= res_done;
            total_value <= 32'(signed'(running_total));
            div_zero    <= zero_div_seen;
            if (item_last) begin
              accept_state  <= AS_ACCEPT;
              running_total <= '0;
              operand_accum <= '0;
              pending_op    <= OP_PLUS;
              skip_rest     <= 1'b0;
              zero_div_seen <= 1'b0;
            end else if (res_done) begin
              skip_rest <= 1'b1;
            end
          end
        end
        default: begin
          res_skip <= res_skip;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_skip_means_dead: assert property (@(posedge clk) disable iff (rst)
    skip_rest |-> (accept_state == AS_DEAD))
    else $error("skipping characters without a dead acceptor");

  a_fold_start_idle: assert property (@(posedge clk) disable iff (rst)
    fold_req.start |-> fold_rsp.idle)
    else $error("fold started while the unit is busy");

  a_ignored_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(done_res && status == STATUS_IGNORED))
    else $error("ignored character flagged as end of expression");

  a_done_while_waiting: assert property (@(posedge clk) disable iff (rst)
    fold_rsp.done |-> (state == CS_WAIT_A || state == CS_WAIT_B))
    else $error("fold finished with no one waiting");

endmodule

// ===== hdl/sqc_fold.sv =====
// Shared add/subtract unit with sequencer: add, shift-add multiply, restoring divide.
module sqc_fold import sqc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fold_req_t              req,
  input  logic [VALUE_WIDTH-1:0] opnd_a,
  input  logic [VALUE_WIDTH-1:0] opnd_b,
  output fold_rsp_t              rsp,
  output logic [VALUE_WIDTH-1:0] result
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(VALUE_WIDTH);

  fold_state_t    state, state_next;
  op_t            op;
  logic [W-1:0]   x;      // operand a, product, dividend/quotient
  logic [W-1:0]   y;      // operand b, multiplier, divisor
  logic [W:0]     acc;    // multiplicand or remainder
  logic [CW-1:0]  cnt;
  logic           neg;
  logic           zflag;

  logic [W:0]     add_a, add_b;
  logic           add_sub;
  logic [W+1:0]   sum;
  logic           last_step;

  assign sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (W+2)'(add_sub);
  assign last_step = (cnt == CW'(W - 1));
  assign result = x;

  always_comb begin
    state_next = state;
    case (state)
      FS_IDLE: begin
        if (req.start) begin
          case (req.op)
            OP_PLUS, OP_MINUS: state_next = FS_ADD;
            OP_TIMES:          state_next = FS_MUL;
            default: begin
              if (opnd_b == '0)          state_next = FS_DONE;
              else if (opnd_a[W-1])      state_next = FS_NEG_A;
              else if (opnd_b[W-1])      state_next = FS_NEG_B;
              else                       state_next = FS_DIV;
            end
          endcase
        end
      end
      FS_ADD:   state_next = FS_DONE;
      FS_MUL:   if (last_step) state_next = FS_DONE;
      FS_NEG_A: state_next = y[W-1] ? FS_NEG_B : FS_DIV;
      FS_NEG_B: state_next = FS_DIV;
      FS_DIV:   if (last_step) state_next = neg ? FS_NEG_Q : FS_DONE;
      FS_NEG_Q: state_next = FS_DONE;
      FS_DONE:  state_next = FS_IDLE;
      default:  state_next = FS_IDLE;
    endcase
  end

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state)
      FS_ADD: begin
        add_a   = {1'b0, x};
        add_b   = {1'b0, y};
        add_sub = (op == OP_MINUS);
      end
      FS_MUL: begin
        add_a = {1'b0, x};
        add_b = {1'b0, acc[W-1:0]};
      end
      FS_NEG_A, FS_NEG_Q: begin
        add_b   = {1'b0, x};
        add_sub = 1'b1;
      end
      FS_NEG_B: begin
        add_b   = {1'b0, y};
        add_sub = 1'b1;
      end
      FS_DIV: begin
        add_a   = {acc[W-1:0], x[W-1]};
        add_b   = {1'b0, y};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
    rsp.idle     = (state == FS_IDLE);
    rsp.done     = (state == FS_DONE);
    rsp.div_zero = zflag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
      zflag <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        FS_IDLE: begin
          if (req.start) begin
            op    <= req.op;
            x     <= opnd_a;
            y     <= opnd_b;
            acc   <= '0;
            cnt   <= '0;
            neg   <= opnd_a[W-1] ^ opnd_b[W-1];
            zflag <= (req.op == OP_DIVIDE) && (opnd_b == '0);
            if (req.op == OP_TIMES) begin
              x   <= '0;
              acc <= {1'b0, opnd_a};
            end
          end
        end
        FS_ADD: x <= sum[W-1:0];
        FS_MUL: begin
          if (y[0]) begin
            x <= sum[W-1:0];
          end
          acc <= {acc[W-1:0], 1'b0};
          y   <= {1'b0, y[W-1:1]};
          cnt <= cnt + 1'b1;
        end
        FS_NEG_A, FS_NEG_Q: x <= sum[W-1:0];
        FS_NEG_B: y <= sum[W-1:0];
        FS_DIV: begin
          // carry out set means the shifted remainder covers the divisor
          acc <= sum[W+1] ? sum[W:0] : add_a;
          x   <= {x[W-2:0], sum[W+1]};
          cnt <= cnt + 1'b1;
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

endmodule
